### design/nmea_rmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_pkg
// shared constants and types for the rmc position parser and its converter
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  // line storage and field sizes
  localparam int LINE_BUFFER_SIZE = 128;
  localparam int LEN_W            = $clog2(LINE_BUFFER_SIZE);
  localparam int FRACTION_DIGITS  = 5;
  localparam int FIELD_DIGITS     = 5;
  localparam int CNT_W            = 3;
  localparam int MIN_FIELD_CHARS  = 5;

  // converter widths
  localparam int E7_W     = 34;
  localparam int DEG_W    = 10;
  localparam int MIN_E5_W = 24;
  localparam int MIN5_W   = 26;
  localparam int PROD_W   = 52;

  // conversion constants: minutes*100/60 done as (minutes*5)/3
  localparam longint DEG_SCALE   = 64'd10_000_000;
  localparam longint RECIP_3     = 64'd44_739_243;
  localparam int     RECIP_SHIFT = 27;

  // characters
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [23:0] PAT_RMC    = 24'h524D43;
  localparam logic [23:0] PAT_ACTIVE = 24'h2C412C;

  // comma positions of interest
  localparam logic [2:0] COMMA_LAT = 3'd3;
  localparam logic [2:0] COMMA_LON = 3'd5;
  localparam logic [2:0] COMMA_MAX = 3'd6;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [FIELD_DIGITS-1:0] bcd_field_t;

  // stage load strobes for the converter pipeline
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } conv_ctl_t;

endpackage : nmea_rmc_pkg
`default_nettype wire

### design/nmea_rmc_coord_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_coord_conv
// three-stage conversion of a bcd dddmm.mmmmm field to 1e-7 degree
// ----------------------------------------------------------------------------
module nmea_rmc_coord_conv
  import nmea_rmc_pkg::*;
(
  input  wire logic              clk,
  input  wire conv_ctl_t         ctl,
  input  wire bcd_field_t        int_digits,
  input  wire bcd_field_t        frac_digits,
  output logic [E7_W-1:0]        value_e7
);

  logic [DEG_W-1:0]    deg_bin;
  logic [MIN_E5_W-1:0] min_e5;
  logic [E7_W-1:0]     deg_e7_s3;
  logic [MIN5_W-1:0]   min5;
  logic [E7_W-1:0]     deg_e7_s4;
  logic [MIN_E5_W-1:0] quo;
  logic [PROD_W-1:0]   prod;

  // stage 2: bcd to binary degrees and minutes in 1e-5
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      deg_bin <= DEG_W'(int_digits[4]) * DEG_W'(100)
               + DEG_W'(int_digits[3]) * DEG_W'(10)
               + DEG_W'(int_digits[2]);
      min_e5  <= MIN_E5_W'(int_digits[1])  * MIN_E5_W'(1_000_000)
               + MIN_E5_W'(int_digits[0])  * MIN_E5_W'(100_000)
               + MIN_E5_W'(frac_digits[4]) * MIN_E5_W'(10_000)
               + MIN_E5_W'(frac_digits[3]) * MIN_E5_W'(1_000)
               + MIN_E5_W'(frac_digits[2]) * MIN_E5_W'(100)
               + MIN_E5_W'(frac_digits[1]) * MIN_E5_W'(10)
               + MIN_E5_W'(frac_digits[0]);
    end
  end

  // stage 3: scale degrees, minutes times five
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      deg_e7_s3 <= E7_W'(deg_bin) * E7_W'(DEG_SCALE);
      min5      <= MIN5_W'({min_e5, 2'b00}) + MIN5_W'(min_e5);
    end
  end

  // stage 4: divide by three via reciprocal
  assign prod = PROD_W'(min5) * PROD_W'(RECIP_3);

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      deg_e7_s4 <= deg_e7_s3;
      quo       <= prod[RECIP_SHIFT +: MIN_E5_W];
    end
  end

  assign value_e7 = deg_e7_s4 + E7_W'(quo);

endmodule : nmea_rmc_coord_conv
`default_nettype wire

### design/nmea_rmc_position_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser
// byte-wise nmea rmc scanner with held fix status, latitude and longitude
// ----------------------------------------------------------------------------
// Takes one received byte per request on the input channel and accepts a new
// byte in every cycle while in_ready is high. Each byte updates the line
// scanner in the cycle it is accepted; a newline (0x0a) ends the line and
// produces one result request holding line_was_rmc and the held fix_valid,
// latitude_e7 and longitude_e7 (1e-7 degree, hemisphere ignored). Other
// bytes give no result. A result is presented on the output after passing
// five registers: a snapshot register, three converter stages (bcd to
// binary, scaling, divide by three through a reciprocal multiply) and the
// output register. Each stage only stalls when the stage after it is full,
// so bytes keep flowing while a result waits on the output, until five
// results are held. A byte arriving when the line already holds
// LINE_BUFFER_SIZE-1 bytes clears the line and is dropped; a zero byte
// hides the rest of the line from the scan. Coordinates update only on an
// rmc line that contains ",A,", and read 0 when fewer than five characters
// follow their comma.
// ----------------------------------------------------------------------------
module nmea_rmc_position_parser
  import nmea_rmc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      rx_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 line_was_rmc,
  output logic                 fix_valid,
  output logic [E7_W-1:0]      latitude_e7,
  output logic [E7_W-1:0]      longitude_e7
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INT,
    PH_FRAC
  } phase_t;

  typedef struct packed {
    logic was_rmc;
    logic fix_new;
    logic lat_upd;
    logic lon_upd;
  } res_flags_t;

  // append a digit to an integer field, saturating at all nines
  function automatic bcd_field_t bcd_append(bcd_field_t f, bcd_digit_t d);
    bcd_field_t r;
    if (f[FIELD_DIGITS-1] != 4'd0) begin
      for (int k = 0; k < FIELD_DIGITS; k++) r[k] = 4'd9;
    end else begin
      r[0] = d;
      for (int k = 1; k < FIELD_DIGITS; k++) r[k] = f[k-1];
    end
    return r;
  endfunction

  // line scanner state
  logic [LEN_W-1:0] line_length, text_length;
  logic             text_ended;
  logic [15:0]      recent_bytes;
  logic             rmc_seen, active_seen;
  logic [2:0]       comma_count;
  logic [LEN_W-1:0] lat_pos, lon_pos;
  phase_t           phase;
  bcd_field_t       lat_int, lat_frac, lon_int, lon_frac;
  logic [CNT_W-1:0] frac_cnt;

  // scanned values for the current byte
  logic [LEN_W-1:0] sc_line_length, sc_text_length;
  logic             sc_text_ended;
  logic [15:0]      sc_recent;
  logic             sc_rmc, sc_active;
  logic [2:0]       sc_count, count_inc;
  logic [LEN_W-1:0] sc_lat_pos, sc_lon_pos;
  phase_t           sc_phase;
  bcd_field_t       sc_lat_int, sc_lat_frac, sc_lon_int, sc_lon_frac;
  logic [CNT_W-1:0] sc_frac_cnt;

  logic [23:0]      window;
  logic             is_digit, lon_sel, drop, is_nl, clear_line, in_fire, produce;
  bcd_field_t       cur_int, cur_frac, int_app, frac_wr;
  logic             lat_short, lon_short;

  // pipeline control
  logic             v1, v2, v3, v4;
  logic             r1, r2, r3, r4, ro;
  conv_ctl_t        ctl;
  res_flags_t       f1, f2, f3, f4;
  bcd_field_t       s1_lat_int, s1_lat_frac, s1_lon_int, s1_lon_frac;
  logic [E7_W-1:0]  lat_val, lon_val;

  assign in_fire = in_valid && in_ready;
  assign drop    = (line_length == LEN_W'(LINE_BUFFER_SIZE - 1));
  assign is_nl   = (rx_byte == CH_NL);
  assign produce = !drop && is_nl;
  assign clear_line = drop || is_nl;

  assign window   = {recent_bytes, rx_byte};
  assign is_digit = (rx_byte >= CH_DIGIT_0) && (rx_byte <= CH_DIGIT_9);
  assign lon_sel  = (comma_count == COMMA_LON);
  assign cur_int  = lon_sel ? lon_int  : lat_int;
  assign cur_frac = lon_sel ? lon_frac : lat_frac;
  assign int_app  = bcd_append(cur_int, rx_byte[3:0]);
  assign count_inc = (comma_count < COMMA_MAX) ? comma_count + 3'd1 : comma_count;

  always_comb begin
    frac_wr = cur_frac;
    for (int k = 0; k < FIELD_DIGITS; k++) begin
      if (frac_cnt == CNT_W'(FIELD_DIGITS - 1 - k)) frac_wr[k] = rx_byte[3:0];
    end
  end

  // scan of one visible character
  always_comb begin
    sc_line_length = line_length + LEN_W'(1);
    sc_text_length = text_length;
    sc_text_ended  = text_ended;
    sc_recent      = recent_bytes;
    sc_rmc         = rmc_seen;
    sc_active      = active_seen;
    sc_count       = comma_count;
    sc_lat_pos     = lat_pos;
    sc_lon_pos     = lon_pos;
    sc_phase       = phase;
    sc_lat_int     = lat_int;
    sc_lat_frac    = lat_frac;
    sc_lon_int     = lon_int;
    sc_lon_frac    = lon_frac;
    sc_frac_cnt    = frac_cnt;
    if (!text_ended) begin
      if (rx_byte == CH_NUL) begin
        sc_text_ended = 1'b1;
      end else begin
        sc_text_length = text_length + LEN_W'(1);
        sc_recent      = window[15:0];
        if (window == PAT_RMC) sc_rmc = 1'b1;
        if (window == PAT_ACTIVE) sc_active = 1'b1;
        unique case (phase)
          PH_INT: begin
            if (is_digit) begin
              if (lon_sel) sc_lon_int = int_app;
              else sc_lat_int = int_app;
            end else if (rx_byte == CH_DOT) begin
              sc_phase = PH_FRAC;
            end else begin
              sc_phase = PH_IDLE;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (frac_cnt < CNT_W'(FRACTION_DIGITS)) begin
                if (lon_sel) sc_lon_frac = frac_wr;
                else sc_lat_frac = frac_wr;
                sc_frac_cnt = frac_cnt + CNT_W'(1);
              end
            end else begin
              sc_phase = PH_IDLE;
            end
          end
          default: ;
        endcase
        if (rx_byte == CH_COMMA) begin
          sc_phase = PH_IDLE;
          sc_count = count_inc;
          if (count_inc == COMMA_LAT) begin
            sc_lat_pos  = sc_text_length;
            sc_phase    = PH_INT;
            sc_frac_cnt = '0;
          end else if (count_inc == COMMA_LON) begin
            sc_lon_pos  = sc_text_length;
            sc_phase    = PH_INT;
            sc_frac_cnt = '0;
          end
        end
      end
    end
  end

  // short fields read as zero
  assign lat_short = (sc_text_length - sc_lat_pos) < LEN_W'(MIN_FIELD_CHARS);
  assign lon_short = (sc_text_length - sc_lon_pos) < LEN_W'(MIN_FIELD_CHARS);

  // line state: cleared on newline and on a full line
  always_ff @(posedge clk) begin
    if (rst || (in_fire && clear_line)) begin
      line_length  <= '0;
      text_length  <= '0;
      text_ended   <= 1'b0;
      recent_bytes <= '0;
      rmc_seen     <= 1'b0;
      active_seen  <= 1'b0;
      comma_count  <= '0;
      lat_pos      <= '0;
      lon_pos      <= '0;
      phase        <= PH_IDLE;
      lat_int      <= '0;
      lat_frac     <= '0;
      lon_int      <= '0;
      lon_frac     <= '0;
      frac_cnt     <= '0;
    end else if (in_fire) begin
      line_length  <= sc_line_length;
      text_length  <= sc_text_length;
      text_ended   <= sc_text_ended;
      recent_bytes <= sc_recent;
      rmc_seen     <= sc_rmc;
      active_seen  <= sc_active;
      comma_count  <= sc_count;
      lat_pos      <= sc_lat_pos;
      lon_pos      <= sc_lon_pos;
      phase        <= sc_phase;
      lat_int      <= sc_lat_int;
      lat_frac     <= sc_lat_frac;
      lon_int      <= sc_lon_int;
      lon_frac     <= sc_lon_frac;
      frac_cnt     <= sc_frac_cnt;
    end
  end

  // each stage moves on when the next one is empty or moving
  assign ro = !out_valid || out_ready;
  assign r4 = !v4 || ro;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign ctl = '{ld2: r2 && v1, ld3: r3 && v2, ld4: r4 && v3};

  // snapshot of the finished line
  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      f1.was_rmc  <= sc_rmc;
      f1.fix_new  <= sc_active;
      f1.lat_upd  <= sc_rmc && sc_active && (sc_count >= COMMA_LAT);
      f1.lon_upd  <= sc_rmc && sc_active && (sc_count >= COMMA_LON);
      s1_lat_int  <= lat_short ? '0 : sc_lat_int;
      s1_lat_frac <= lat_short ? '0 : sc_lat_frac;
      s1_lon_int  <= lon_short ? '0 : sc_lon_int;
      s1_lon_frac <= lon_short ? '0 : sc_lon_frac;
    end
    if (ctl.ld2) f2 <= f1;
    if (ctl.ld3) f3 <= f2;
    if (ctl.ld4) f4 <= f3;
  end

  nmea_rmc_coord_conv u_lat_conv (
    .clk         (clk),
    .ctl         (ctl),
    .int_digits  (s1_lat_int),
    .frac_digits (s1_lat_frac),
    .value_e7    (lat_val)
  );

  nmea_rmc_coord_conv u_lon_conv (
    .clk         (clk),
    .ctl         (ctl),
    .int_digits  (s1_lon_int),
    .frac_digits (s1_lon_frac),
    .value_e7    (lon_val)
  );

  // valid bits and the output register, which also holds the fix and position
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      out_valid    <= 1'b0;
      line_was_rmc <= 1'b0;
      fix_valid    <= 1'b0;
      latitude_e7  <= '0;
      longitude_e7 <= '0;
    end else begin
      if (r1) v1 <= in_valid && produce;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (ro) out_valid <= v4;
      if (ro && v4) begin
        line_was_rmc <= f4.was_rmc;
        if (f4.was_rmc) fix_valid <= f4.fix_new;
        if (f4.lat_upd) latitude_e7 <= lat_val;
        if (f4.lon_upd) longitude_e7 <= lon_val;
      end
    end
  end

endmodule : nmea_rmc_position_parser
`default_nettype wire

### design/nmea_rmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_checker
// port-level checks on the rmc position parser, bound to the top level
// ----------------------------------------------------------------------------
module nmea_rmc_checker
  import nmea_rmc_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic [7:0]      rx_byte,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            line_was_rmc,
  input wire logic            fix_valid,
  input wire logic [E7_W-1:0] latitude_e7,
  input wire logic [E7_W-1:0] longitude_e7
);

  // a waiting input request holds its byte
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("input request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_was_rmc)
      && $stable(fix_valid) && $stable(latitude_e7) && $stable(longitude_e7))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // with no result pending the pipeline cannot be full
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // coordinates stay within dddmm.mmmmm range
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude_e7 <= 34'd10006666665)
      && (longitude_e7 <= 34'd10006666665))
    else $error("coordinate out of range");

endmodule : nmea_rmc_checker

bind nmea_rmc_position_parser nmea_rmc_checker u_nmea_rmc_checker (.*);
`default_nettype wire
